@@ hdl/ctle_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Client table package
// Shared request/response types and request codes for the client table.
// ----------------------------------------------------------------------------
package ctle_pkg;

   localparam logic [1:0] REQ_LOOKUP = 2'd0;
   localparam logic [1:0] REQ_UPDATE = 2'd1;
   localparam logic [1:0] REQ_PURGE  = 2'd2;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] peer_ip;
      logic [15:0] peer_port;
      logic [31:0] rx_sec;
      logic [31:0] rx_nsec;
      logic [31:0] tx_sec;
      logic [31:0] tx_nsec;
      logic [47:0] now_ms;
   } req_type_type;

   typedef struct packed {
      logic        ok;
      logic        was_found;
      logic [3:0]  slot_index;
      logic [15:0] port_out;
      logic [31:0] prev_rx_sec;
      logic [31:0] prev_rx_nsec;
      logic [31:0] prev_tx_sec;
      logic [31:0] prev_tx_nsec;
      logic [47:0] last_seen_out;
   } rsp_type;

   // Stored record of one table slot, kept in RAM.
   typedef struct packed {
      logic [31:0] ip;
      logic [15:0] port;
      logic [31:0] rx_sec;
      logic [31:0] rx_nsec;
      logic [31:0] tx_sec;
      logic [31:0] tx_nsec;
      logic [47:0] last_seen;
   } entry_type;

endpackage
`default_nettype wire

@@ hdl/ctle_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module ctle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

@@ hdl/ctle_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Client table front end
// Two-entry request queue between the input port and the table engine.
// ----------------------------------------------------------------------------
module ctle_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   output logic                       full,
   input  wire ctle_pkg::req_type_type push_data,
   output logic                       q_valid,
   input  wire logic                  q_take,
   output ctle_pkg::req_type_type     q_data
);
   ctle_pkg::req_type_type slot_ff [2];
   ctle_pkg::req_type_type slot_in [2];
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign q_valid = (count_ff != 2'd0);
   assign q_data  = slot_ff[0];
   assign do_push = push && !full;
   assign do_pop  = q_take && q_valid;

   // Shift queue: head in slot 0.
   always_comb begin
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      count_in   = count_ff;
      if (do_pop) begin
         slot_in[0] = slot_ff[1];
         count_in   = count_in - 2'd1;
      end
      if (do_push) begin
         if (count_in == 2'd0) begin
            slot_in[0] = push_data;
         end else begin
            slot_in[1] = push_data;
         end
         count_in = count_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end
endmodule
`default_nettype wire

@@ hdl/ctle_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Client table engine
// Scans one slot a cycle; purges in the scan, or then matches or allocates.
// ----------------------------------------------------------------------------
module ctle_engine #(
   parameter int ENTRIES = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [31:0]            idle_timeout,
   input  wire logic                   q_valid,
   output logic                        q_take,
   input  wire ctle_pkg::req_type_type q_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_take,
   output ctle_pkg::rsp_type           rsp_data
);
   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RD = 1 << AW;
   localparam int CW = AW + 1;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_READ   = 5'b00100,
      ST_WRITE  = 5'b01000,
      ST_OUTPUT = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   ctle_pkg::req_type_type req_ff;
   logic [ENTRIES-1:0] valid_ff;
   logic [CW-1:0] idx_ff;       // address issued
   logic          rd_pend_ff;   // read data of previous address arriving
   logic [AW-1:0] rd_idx_ff;
   logic          hit_ff, free_ff, old_ff;
   logic [AW-1:0] sel_ff;
   logic [47:0]   oldest_ff;
   ctle_pkg::rsp_type out_ff;
   logic          out_valid_ff;

   logic            wr_en;
   logic [AW-1:0]   wr_addr, rd_addr;
   ctle_pkg::entry_type wr_data, rd_data;

   ctle_ram #(.WIDTH($bits(ctle_pkg::entry_type)), .DEPTH(RD)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   logic        is_fc, scan_last, cur_valid, expired;
   logic [47:0] age;

   assign is_fc     = (req_ff.req_type == ctle_pkg::REQ_LOOKUP) ||
                      (req_ff.req_type == ctle_pkg::REQ_UPDATE);
   assign cur_valid = valid_ff[rd_idx_ff];
   assign age       = req_ff.now_ms - rd_data.last_seen;
   assign expired   = cur_valid && (req_ff.now_ms > rd_data.last_seen) &&
                      (age > {16'd0, idle_timeout});
   assign scan_last = rd_pend_ff && (idx_ff == CW'(ENTRIES));
   assign q_take    = (state_ff == ST_IDLE) && q_valid;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // RAM address and write selection.
   always_comb begin
      rd_addr = (state_ff == ST_SCAN) ? idx_ff[AW-1:0] : sel_ff;
      wr_en   = 1'b0;
      wr_addr = sel_ff;
      wr_data = rd_data;
      if (state_ff == ST_SCAN && rd_pend_ff && req_ff.req_type == ctle_pkg::REQ_PURGE
          && expired) begin
         wr_en   = 1'b1;
         wr_addr = rd_idx_ff;
         wr_data = '0;
      end else if (state_ff == ST_WRITE) begin
         wr_en = 1'b1;
         if (!hit_ff) begin
            wr_data           = '0;
            wr_data.ip        = req_ff.peer_ip;
            wr_data.port      = req_ff.peer_port;
            wr_data.last_seen = req_ff.now_ms;
         end
         if (req_ff.req_type == ctle_pkg::REQ_UPDATE) begin
            wr_data.port      = req_ff.peer_port;
            wr_data.rx_sec    = req_ff.rx_sec;
            wr_data.rx_nsec   = req_ff.rx_nsec;
            wr_data.tx_sec    = req_ff.tx_sec;
            wr_data.tx_nsec   = req_ff.tx_nsec;
            wr_data.last_seen = req_ff.now_ms;
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (q_valid) begin
            state_in = ST_SCAN;
         end
         ST_SCAN:   begin
            if (!is_fc) begin
               if (scan_last || req_ff.req_type != ctle_pkg::REQ_PURGE) begin
                  state_in = ST_OUTPUT;
               end
            end else if (rd_pend_ff && cur_valid && rd_data.ip == req_ff.peer_ip) begin
               state_in = ST_READ;
            end else if (scan_last) begin
               state_in = ST_READ;
            end
         end
         ST_READ:   state_in = ST_WRITE;
         ST_WRITE:  state_in = ST_OUTPUT;
         ST_OUTPUT: if (!out_valid_ff) begin
            state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_take) begin
         req_ff <= q_data;
      end
      // Scan bookkeeping.
      if (state_ff == ST_IDLE) begin
         idx_ff     <= '0;
         rd_pend_ff <= 1'b0;
         hit_ff     <= 1'b0;
         free_ff    <= 1'b0;
         old_ff     <= 1'b0;
         sel_ff     <= '0;
         oldest_ff  <= '0;
      end else if (state_ff == ST_SCAN) begin
         if (idx_ff != CW'(ENTRIES)) begin
            idx_ff <= idx_ff + CW'(1);
         end
         rd_pend_ff <= (idx_ff != CW'(ENTRIES));
         rd_idx_ff  <= idx_ff[AW-1:0];
         if (rd_pend_ff && is_fc) begin
            priority if (cur_valid && rd_data.ip == req_ff.peer_ip) begin
               hit_ff <= 1'b1;
               sel_ff <= rd_idx_ff;
            end else if (!cur_valid) begin
               free_ff <= 1'b1;
               sel_ff  <= rd_idx_ff;
            end else if (!free_ff && (!old_ff || rd_data.last_seen < oldest_ff)) begin
               old_ff    <= 1'b1;
               sel_ff    <= rd_idx_ff;
               oldest_ff <= rd_data.last_seen;
            end
         end
      end
      // Result capture: WRITE sees the chosen entry on rd_data.
      if (state_ff == ST_WRITE) begin
         out_ff.ok         <= 1'b1;
         out_ff.was_found  <= hit_ff;
         out_ff.slot_index <= 4'(sel_ff);
         if (hit_ff) begin
            out_ff.port_out      <= rd_data.port;
            out_ff.prev_rx_sec   <= rd_data.rx_sec;
            out_ff.prev_rx_nsec  <= rd_data.rx_nsec;
            out_ff.prev_tx_sec   <= rd_data.tx_sec;
            out_ff.prev_tx_nsec  <= rd_data.tx_nsec;
            out_ff.last_seen_out <= rd_data.last_seen;
         end else begin
            out_ff.port_out      <= req_ff.peer_port;
            out_ff.prev_rx_sec   <= '0;
            out_ff.prev_rx_nsec  <= '0;
            out_ff.prev_tx_sec   <= '0;
            out_ff.prev_tx_nsec  <= '0;
            out_ff.last_seen_out <= req_ff.now_ms;
         end
      end else if (state_ff == ST_SCAN && !is_fc) begin
         out_ff    <= '0;
         out_ff.ok <= (req_ff.req_type == ctle_pkg::REQ_PURGE);
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_SCAN && rd_pend_ff && req_ff.req_type == ctle_pkg::REQ_PURGE
             && expired) begin
            valid_ff[rd_idx_ff] <= 1'b0;
         end
         if (state_ff == ST_WRITE) begin
            valid_ff[sel_ff] <= 1'b1;
         end
         if (state_ff == ST_OUTPUT && state_in == ST_OUTPUT && !out_valid_ff) begin
            out_valid_ff <= 1'b1;
         end else if (out_valid_ff && rsp_take) begin
            out_valid_ff <= 1'b0;
         end
         if (state_in == ST_OUTPUT && state_ff != ST_OUTPUT) begin
            out_valid_ff <= 1'b1;
         end
      end
   end
endmodule
`default_nettype wire

@@ hdl/client_table_lru_expiry.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Client table with LRU replacement and idle expiry
// Port   | Direction | Handshake
// req_   | in        | push / full
// rsp_   | out       | pop / empty
// csr_   | in        | csr_wr_en, no wait
// A lookup or update that misses scans every slot; a hit stops the scan at the
// matching slot. A purge scans every slot, and an unused code goes straight
// to the result. The engine takes the next request only after the result
// transfer. Valid bits clear at reset, so no clearing pass is needed. Up to
// two requests queue ahead of the engine; a stalled result holds the engine
// but not the request queue.
// ----------------------------------------------------------------------------
module client_table_lru_expiry #(
   parameter int ENTRIES = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   output logic                        full,
   input  wire ctle_pkg::req_type_type req_data,
   output logic                        empty,
   input  wire logic                   pop,
   output ctle_pkg::rsp_type           rsp_data,
   input  wire logic                   csr_wr_en,
   input  wire logic [31:0]            csr_wr_data
);
   logic [31:0] timeout_ff;
   logic        q_valid, q_take, rsp_valid;
   ctle_pkg::req_type_type q_data;

   // Idle timeout register.
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= 32'd300000;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   ctle_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .push_data(req_data),
      .q_valid  (q_valid),
      .q_take   (q_take),
      .q_data   (q_data)
   );

   ctle_engine #(.ENTRIES(ENTRIES)) u_engine (
      .clock       (clock),
      .reset       (reset),
      .idle_timeout(timeout_ff),
      .q_valid     (q_valid),
      .q_take      (q_take),
      .q_data      (q_data),
      .rsp_valid   (rsp_valid),
      .rsp_take    (pop),
      .rsp_data    (rsp_data)
   );

   assign empty = !rsp_valid;
endmodule
`default_nettype wire
